/* sv/vsd_pkg.sv */
package vsd_pkg;

  // Byte layout of the encoding
  localparam int unsigned MoreBitIdx = 7;
  localparam int unsigned SignBitIdx = 6;
  localparam logic [7:0]  Group7Mask = 8'h7F;
  localparam logic [7:0]  Group6Mask = 8'h3F;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] CountMax = 4'd15;

  // Shift amount covers 7 * CountMax
  localparam int unsigned ShiftW = 7;
  // Placed group width: 7 payload bits shifted by up to 7 * CountMax
  localparam int unsigned PlaceW = 112;

  // Decode state carried between bytes of one varint
  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] count;
    logic              neg;
    logic              ovf;
  } vsd_state_t;

  // One decoded result beat
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] bytes_used;
    logic              overflow;
  } vsd_result_t;

endpackage

/* sv/vsd_step.sv */
module vsd_step
  import vsd_pkg::*;
(
  input  vsd_state_t  cur,
  input  logic [7:0]  byte_in,
  input  logic        signed_mode,
  output vsd_state_t  nxt,
  output logic        done,
  output vsd_result_t res
);

  logic              first_signed;
  logic [ShiftW-1:0] shift;
  logic [PlaceW-1:0] placed;
  vsd_state_t        upd;

  // First byte in signed mode carries sign plus six magnitude bits
  assign first_signed = (cur.count == '0) && signed_mode;

  // Group position: 7 * count, one less in signed mode
  assign shift = ShiftW'({3'b000, cur.count} << 3) - ShiftW'(cur.count)
               - ShiftW'(signed_mode);

  // Bits landing at 64 or above are dropped and flagged
  assign placed = PlaceW'(byte_in & Group7Mask) << shift;

  always_comb begin
    if (first_signed) begin
      upd.acc = ValueW'(byte_in & Group6Mask);
      upd.neg = byte_in[SignBitIdx];
      upd.ovf = cur.ovf;
    end else begin
      upd.acc = cur.acc | placed[ValueW-1:0];
      upd.neg = cur.neg;
      upd.ovf = cur.ovf | (|placed[PlaceW-1:ValueW]);
    end
    upd.count = (cur.count == CountMax) ? CountMax : cur.count + CountW'(1);
  end

  // A byte without the continuation bit ends the varint
  assign done = ~byte_in[MoreBitIdx];
  assign nxt  = done ? '0 : upd;

  assign res.value      = upd.neg ? (ValueW'(0) - upd.acc) : upd.acc;
  assign res.bytes_used = upd.count;
  assign res.overflow   = upd.ovf;

endmodule

/* sv/varint_stream_decoder.sv */
// Varint stream decoder: takes one encoded byte per beat and emits one 64-bit
// value (with byte count and overflow flag) for each byte whose bit 7 is clear.
// cfg_wr_data selects unsigned LEB128 (0) or sign-magnitude with the sign in
// the first byte (1); write it only while no byte or varint is in flight. A byte
// is taken every cycle when the result side keeps up. A final byte goes from the
// input register through the decode stage (group shifter, 64-bit OR and negate)
// into the result register, which raises out_valid and holds the result until
// out_ready takes it. A result held by a stalled out_ready blocks only a final
// byte in the input register; continuation bytes still pass.
module varint_stream_decoder
  import vsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] out_value,
  output logic [CountW-1:0] out_bytes_used,
  output logic              out_overflow,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  logic        signed_mode_r;
  logic        in_valid_r;
  logic [7:0]  byte_r;
  vsd_state_t  state_r;
  vsd_state_t  state_nxt;
  logic        out_valid_r;
  vsd_result_t res_r;
  vsd_result_t res_nxt;
  logic        done;
  logic        out_free;
  logic        stage_go;

  vsd_step u_step (
    .cur         (state_r),
    .byte_in     (byte_r),
    .signed_mode (signed_mode_r),
    .nxt         (state_nxt),
    .done        (done),
    .res         (res_nxt)
  );

  // Handshake: the decode stage moves unless it has a result and no room
  assign out_free = ~out_valid_r | out_ready;
  assign stage_go = in_valid_r & (~done | out_free);
  assign in_ready = ~in_valid_r | stage_go;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        signed_mode_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (stage_go) begin
        state_r <= state_nxt;
      end
      if (stage_go && done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
    if (stage_go && done) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = res_r.value;
  assign out_bytes_used = res_r.bytes_used;
  assign out_overflow   = res_r.overflow;

endmodule
